// ----- rtl/extendible_hash_table_unit_macros.svh -----
// Assertion macros used by the checker file of the hash table unit.
`ifndef EXTENDIBLE_HASH_TABLE_UNIT_MACROS_SVH
`define EXTENDIBLE_HASH_TABLE_UNIT_MACROS_SVH
// same-cycle implication, sampled on clk, off during reset
`define EHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hash table check failed");
// next-cycle implication, sampled on clk, off during reset
`define EHT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hash table check failed");
`endif

// ----- rtl/ehash_pkg.sv -----
// Shared constants and types of the extendible hash table unit.
`default_nettype none
package ehash_pkg;
  localparam int MAX_DEPTH_DEF  = 8;
  localparam int BUCKET_CAP_DEF = 8;
  localparam int KEY_W          = 32;
  localparam int ROW_W          = 31;
  localparam int REC_W          = KEY_W + ROW_W;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_KEY   = 2'd3;

  localparam logic [KEY_W-1:0] BAD_KEY = 32'h8000_0000;

  typedef struct packed {
    logic [KEY_W-1:0] mag;  // absolute value of the key
    logic             bad;  // key has no absolute value
  } hash_res_t;
endpackage
`default_nettype wire

// ----- rtl/ehash_ram.sv -----
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module ehash_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/ehash_hash.sv -----
// Key hash (absolute value) and bit-reversed directory index.
`default_nettype none
module ehash_hash
  import ehash_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int AW        = MAX_DEPTH,
  parameter int DW        = $clog2(MAX_DEPTH + 1)
) (
  input  wire logic [KEY_W-1:0] key,
  input  wire logic [DW-1:0]    gd,
  output hash_res_t             res,
  output logic      [AW-1:0]    idx
);
  logic [AW-1:0] rev;
  logic [DW-1:0] sh;

  always_comb begin
    res.mag = key[KEY_W-1] ? (~key + 1'b1) : key;
    res.bad = (key == BAD_KEY);
    for (int i = 0; i < AW; i++) begin
      rev[AW-1-i] = res.mag[i];
    end
    // hash bit 0 lands on the top index bit of a gd-bit index
    sh  = DW'(AW) - gd;
    idx = rev >> sh;
  end
endmodule
`default_nettype wire

// ----- rtl/extendible_hash_table_unit.sv -----
// Top level of the extendible hash table unit: sequencer, memories and result register.
//
// Extendible hash table engine for signed 32-bit keys. One word in, one word out, one
// item at a time: in_ready is high only while the sequencer is idle. Every memory
// access goes through single-port-read RAMs with registered read data. A lookup
// scans the records of the addressed bucket; a full bucket is split, moving its
// records and repointing directory entries, or the directory is doubled first.
// After reset, and for every clear, a sweep over all 2^MAX_DEPTH entries zeroes the
// directory and the bucket fill/depth table; no input word is taken during the reset
// sweep. start_depth (cfg port, always ready) sets the depth a clear installs,
// saturating at MAX_DEPTH. Record storage is never cleared; only entries below a
// bucket's fill are read.
`default_nettype none
module extendible_hash_table_unit
  import ehash_pkg::*;
#(
  parameter int MAX_DEPTH       = MAX_DEPTH_DEF,
  parameter int BUCKET_CAPACITY = BUCKET_CAP_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [KEY_W-1:0]  in_key,
  input  wire logic [ROW_W-1:0]  in_row,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [1:0]        out_status,
  output logic      [ROW_W-1:0]  out_found_row,
  output logic      [3:0]        out_depth_now,
  output logic signed [31:0]     out_largest_row,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [3:0]        cfg_start_depth
);
  localparam int AW   = MAX_DEPTH;                  // bucket number / dir index
  localparam int DW   = $clog2(MAX_DEPTH + 1);      // depth values
  localparam int FW   = $clog2(BUCKET_CAPACITY + 1);// fill values
  localparam int MW   = DW + FW;                    // {local depth, fill}
  localparam int NB   = 1 << MAX_DEPTH;
  localparam int NREC = NB * BUCKET_CAPACITY;
  localparam int RAW  = (NREC > 1) ? $clog2(NREC) : 1;
  localparam int CW   = (AW > FW) ? AW : FW;

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_IDX     = 4'd2;
  localparam logic [3:0] S_DIR     = 4'd3;
  localparam logic [3:0] S_META    = 4'd4;
  localparam logic [3:0] S_SPL_RD  = 4'd5;
  localparam logic [3:0] S_SPL_WR  = 4'd6;
  localparam logic [3:0] S_SPL_M0  = 4'd7;
  localparam logic [3:0] S_SPL_M1  = 4'd8;
  localparam logic [3:0] S_SPL_DIR = 4'd9;
  localparam logic [3:0] S_DBL_RD  = 4'd10;
  localparam logic [3:0] S_DBL_WR  = 4'd11;
  localparam logic [3:0] S_LK_RD   = 4'd12;
  localparam logic [3:0] S_LK_CHK  = 4'd13;
  localparam logic [3:0] S_RESP    = 4'd14;

  // sequencer state
  logic [3:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DW-1:0]     gd_r, gd_nxt;
  logic [AW:0]       nfb_r, nfb_nxt;
  logic signed [31:0] maxrow_r, maxrow_nxt;
  logic              clr_resp_r, clr_resp_nxt;
  // item being worked on
  logic [1:0]        op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [AW-1:0]     b_r, b_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [DW-1:0]     ld_r, ld_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic              side_r, side_nxt;
  logic [FW-1:0]     nk_r, nk_nxt;
  logic [FW-1:0]     nm_r, nm_nxt;
  logic [AW-1:0]     nb_r, nb_nxt;
  logic [AW-1:0]     start_r, start_nxt;
  logic [AW-1:0]     half_r, half_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [ROW_W-1:0]  res_found_r, res_found_nxt;
  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [ROW_W-1:0]  out_found_r, out_found_nxt;
  logic [3:0]        out_depth_r, out_depth_nxt;
  logic signed [31:0] out_largest_r, out_largest_nxt;
  logic [3:0]        start_depth_r, start_depth_nxt;

  // memory ports
  logic              dir_we;
  logic [AW-1:0]     dir_waddr, dir_wdata, dir_raddr, dir_rdata;
  logic              meta_we;
  logic [AW-1:0]     meta_waddr;
  logic [MW-1:0]     meta_wdata, meta_rdata;
  logic              rec_we;
  logic [RAW-1:0]    rec_waddr, rec_raddr;
  logic [REC_W-1:0]  rec_wdata, rec_rdata;

  // shared hash unit
  logic [KEY_W-1:0]  hash_key;
  hash_res_t         hres;
  logic [AW-1:0]     hidx;

  // decoded helpers
  logic [FW-1:0]     meta_fill;
  logic [DW-1:0]     meta_ld;
  logic [KEY_W-1:0]  mag_sh;
  logic [KEY_W-1:0]  rec_key;
  logic [ROW_W-1:0]  rec_row;
  logic [AW:0]       span;
  logic [AW-1:0]     span_mask, base, half_v;
  logic [DW-1:0]     start_sat;

  function automatic logic [RAW-1:0] rec_at(input logic [AW-1:0] b, input logic [CW-1:0] off);
    rec_at = RAW'(b * BUCKET_CAPACITY + off);
  endfunction

  ehash_ram #(.WIDTH(AW), .DEPTH(NB), .ADDR_W(AW)) u_dir (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_rdata)
  );

  ehash_ram #(.WIDTH(MW), .DEPTH(NB), .ADDR_W(AW)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(dir_rdata), .rdata(meta_rdata)
  );

  ehash_ram #(.WIDTH(REC_W), .DEPTH(NREC), .ADDR_W(RAW)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );

  ehash_hash #(.MAX_DEPTH(MAX_DEPTH), .AW(AW), .DW(DW)) u_hash (
    .key(hash_key), .gd(gd_r), .res(hres), .idx(hidx)
  );

  assign in_ready      = (state_r == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_found_row = out_found_r;
  assign out_depth_now = out_depth_r;
  assign out_largest_row = out_largest_r;

  assign meta_fill = meta_rdata[FW-1:0];
  assign meta_ld   = meta_rdata[MW-1:FW];
  assign rec_key   = rec_rdata[REC_W-1:ROW_W];
  assign rec_row   = rec_rdata[ROW_W-1:0];
  assign mag_sh    = hres.mag >> (state_r == S_SPL_WR ? ld_r : meta_ld);

  // split geometry: half of the directory range that shared the old bucket
  assign span      = (AW+1)'(1) << (gd_r - ld_r);
  assign span_mask = AW'(span - 1'b1);
  assign base      = idx_r & ~span_mask;
  assign half_v    = AW'(span >> 1);
  assign start_sat = (start_depth_r > MAX_DEPTH) ? DW'(MAX_DEPTH) : DW'(start_depth_r);

  always_comb begin
    case (state_r)
      S_IDLE:   hash_key = in_key;
      S_SPL_WR: hash_key = rec_key;
      default:  hash_key = key_r;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    gd_nxt          = gd_r;
    nfb_nxt         = nfb_r;
    maxrow_nxt      = maxrow_r;
    clr_resp_nxt    = clr_resp_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    row_nxt         = row_r;
    b_nxt           = b_r;
    idx_nxt         = idx_r;
    ld_nxt          = ld_r;
    fill_nxt        = fill_r;
    side_nxt        = side_r;
    nk_nxt          = nk_r;
    nm_nxt          = nm_r;
    nb_nxt          = nb_r;
    start_nxt       = start_r;
    half_nxt        = half_r;
    res_status_nxt  = res_status_r;
    res_found_nxt   = res_found_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_found_nxt   = out_found_r;
    out_depth_nxt   = out_depth_r;
    out_largest_nxt = out_largest_r;
    start_depth_nxt = cfg_valid ? cfg_start_depth : start_depth_r;

    dir_we     = 1'b0;
    dir_waddr  = cnt_r[AW-1:0];
    dir_wdata  = '0;
    dir_raddr  = hidx;
    meta_we    = 1'b0;
    meta_waddr = cnt_r[AW-1:0];
    meta_wdata = '0;
    rec_we     = 1'b0;
    rec_waddr  = rec_at(b_r, CW'(fill_r));
    rec_wdata  = {key_r, row_r};
    rec_raddr  = rec_at(b_r, cnt_r);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // zero directory and bucket table, one entry a cycle
      S_CLR: begin
        dir_we  = 1'b1;
        meta_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[AW-1:0] == {AW{1'b1}}) begin
          cnt_nxt        = '0;
          res_status_nxt = ST_OK;
          res_found_nxt  = '0;
          state_nxt      = clr_resp_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_opcode;
          key_nxt        = in_key;
          row_nxt        = in_row;
          res_found_nxt  = '0;
          res_status_nxt = ST_OK;
          case (in_opcode)
            OP_INSERT, OP_LOOKUP: begin
              if (hres.bad) begin
                res_status_nxt = ST_BAD_KEY;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_IDX;
              end
            end
            OP_CLEAR: begin
              gd_nxt       = start_sat;
              nfb_nxt      = (AW+1)'(1);
              maxrow_nxt   = -32'sd1;
              cnt_nxt      = '0;
              clr_resp_nxt = 1'b1;
              state_nxt    = S_CLR;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_IDX: begin
        idx_nxt   = hidx;
        state_nxt = S_DIR;
      end
      S_DIR: begin
        b_nxt     = dir_rdata;
        state_nxt = S_META;
      end
      S_META: begin
        ld_nxt   = meta_ld;
        fill_nxt = meta_fill;
        cnt_nxt  = '0;
        if (op_r == OP_LOOKUP) begin
          if (meta_fill == '0) begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_LK_RD;
          end
        end else if (meta_fill < FW'(BUCKET_CAPACITY)) begin
          rec_we     = 1'b1;
          rec_waddr  = rec_at(b_r, CW'(meta_fill));
          meta_we    = 1'b1;
          meta_waddr = b_r;
          meta_wdata = {meta_ld, FW'(meta_fill + 1'b1)};
          if ($signed({1'b0, row_r}) > maxrow_r) begin
            maxrow_nxt = $signed({1'b0, row_r});
          end
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
        end else if (meta_ld < gd_r) begin
          if (nfb_r[AW]) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_RESP;
          end else begin
            nb_nxt    = nfb_r[AW-1:0];
            nfb_nxt   = nfb_r + 1'b1;
            side_nxt  = mag_sh[0];
            nk_nxt    = '0;
            nm_nxt    = '0;
            state_nxt = S_SPL_RD;
          end
        end else if (gd_r < DW'(MAX_DEPTH)) begin
          cnt_nxt   = CW'(((AW+1)'(2) << gd_r) - 1'b1);
          state_nxt = S_DBL_RD;
        end else begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_RESP;
        end
      end
      S_SPL_RD: begin
        state_nxt = S_SPL_WR;
      end
      // compact kept records in place, move the rest to the new bucket
      S_SPL_WR: begin
        rec_we    = 1'b1;
        rec_wdata = rec_rdata;
        if (mag_sh[0] == side_r) begin
          rec_waddr = rec_at(b_r, CW'(nk_r));
          nk_nxt    = nk_r + 1'b1;
        end else begin
          rec_waddr = rec_at(nb_r, CW'(nm_r));
          nm_nxt    = nm_r + 1'b1;
        end
        if (cnt_r == CW'(fill_r - 1'b1)) begin
          state_nxt = S_SPL_M0;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_SPL_RD;
        end
      end
      S_SPL_M0: begin
        meta_we    = 1'b1;
        meta_waddr = b_r;
        meta_wdata = {DW'(ld_r + 1'b1), nk_r};
        state_nxt  = S_SPL_M1;
      end
      S_SPL_M1: begin
        meta_we    = 1'b1;
        meta_waddr = nb_r;
        meta_wdata = {DW'(ld_r + 1'b1), nm_r};
        half_nxt   = half_v;
        start_nxt  = side_r ? base : AW'(base + half_v);
        cnt_nxt    = '0;
        state_nxt  = S_SPL_DIR;
      end
      S_SPL_DIR: begin
        dir_we    = 1'b1;
        dir_waddr = AW'(start_r + cnt_r[AW-1:0]);
        dir_wdata = nb_r;
        if (cnt_r[AW-1:0] == AW'(half_r - 1'b1)) begin
          state_nxt = S_IDX;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // top-down copy: entry i takes entry i/2
      S_DBL_RD: begin
        dir_raddr = cnt_r[AW-1:0] >> 1;
        state_nxt = S_DBL_WR;
      end
      S_DBL_WR: begin
        dir_we    = 1'b1;
        dir_wdata = dir_rdata;
        if (cnt_r == '0) begin
          gd_nxt    = gd_r + 1'b1;
          state_nxt = S_IDX;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_DBL_RD;
        end
      end
      S_LK_RD: begin
        state_nxt = S_LK_CHK;
      end
      S_LK_CHK: begin
        if (rec_key == key_r && rec_row >= row_r) begin
          res_status_nxt = ST_OK;
          res_found_nxt  = rec_row;
          state_nxt      = S_RESP;
        end else if (cnt_r == CW'(fill_r - 1'b1)) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_LK_RD;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_found_nxt   = res_found_r;
          out_depth_nxt   = 4'(gd_r);
          out_largest_nxt = maxrow_r;
          clr_resp_nxt    = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      cnt_r         <= '0;
      gd_r          <= '0;
      nfb_r         <= (AW+1)'(1);
      maxrow_r      <= -32'sd1;
      clr_resp_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      start_depth_r <= '0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      gd_r          <= gd_nxt;
      nfb_r         <= nfb_nxt;
      maxrow_r      <= maxrow_nxt;
      clr_resp_r    <= clr_resp_nxt;
      out_valid_r   <= out_valid_nxt;
      start_depth_r <= start_depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    key_r         <= key_nxt;
    row_r         <= row_nxt;
    b_r           <= b_nxt;
    idx_r         <= idx_nxt;
    ld_r          <= ld_nxt;
    fill_r        <= fill_nxt;
    side_r        <= side_nxt;
    nk_r          <= nk_nxt;
    nm_r          <= nm_nxt;
    nb_r          <= nb_nxt;
    start_r       <= start_nxt;
    half_r        <= half_nxt;
    res_status_r  <= res_status_nxt;
    res_found_r   <= res_found_nxt;
    out_status_r  <= out_status_nxt;
    out_found_r   <= out_found_nxt;
    out_depth_r   <= out_depth_nxt;
    out_largest_r <= out_largest_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/ehash_chk.sv -----
// Port-level checker for the hash table unit, bound to the top level.
`default_nettype none
`include "extendible_hash_table_unit_macros.svh"
module ehash_chk
  import ehash_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [1:0]       out_status,
  input wire logic [ROW_W-1:0] out_found_row,
  input wire logic [3:0]       out_depth_now
);
  `EHT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_found_row))
  `EHT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `EHT_ASSERT_IMP(a_found_only_ok, out_valid && out_found_row != '0, out_status == ST_OK)
  `EHT_ASSERT_IMP(a_depth_range, out_valid, (MAX_DEPTH > 15) || (out_depth_now <= MAX_DEPTH))
endmodule

bind extendible_hash_table_unit ehash_chk #(.MAX_DEPTH(MAX_DEPTH)) u_ehash_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_found_row(out_found_row), .out_depth_now(out_depth_now)
);
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the extendible hash table unit.
module tb_top;
  import ehash_pkg::*;

  // opcode 3 is unused by the block: no state change, status ok
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DEPTH_MAX  = 8;
  localparam int BKT_CAP    = 8;
  localparam int NUM_BKT    = 1 << DEPTH_MAX;
  localparam int WDOG_LIMIT = 20000;  // idle cycles

  typedef struct {
    logic [1:0]  opcode;
    logic [31:0] key;
    logic [30:0] row;
  } op_word_t;

  typedef struct {
    logic [1:0]         status;
    logic [30:0]        found_row;
    logic [3:0]         depth_now;
    logic signed [31:0] largest_row;
  } answer_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_opcode;
  logic [31:0] in_key;
  logic [30:0] in_row;
  logic out_valid, out_ready;
  logic [1:0] out_status;
  logic [30:0] out_found_row;
  logic [3:0] out_depth_now;
  logic signed [31:0] out_largest_row;
  logic cfg_valid, cfg_ready;
  logic [3:0] cfg_start_depth;

  extendible_hash_table_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_key(in_key), .in_row(in_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_found_row(out_found_row),
    .out_depth_now(out_depth_now), .out_largest_row(out_largest_row),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_start_depth(cfg_start_depth)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------------------
  // Table shadow: directory, buckets, depths, allocator, largest row
  // ---------------------------------------------------------------------------
  logic [7:0]  tbl_dir [NUM_BKT];
  logic [31:0] rec_key [NUM_BKT][BKT_CAP];
  logic [30:0] rec_row [NUM_BKT][BKT_CAP];
  int          bkt_fill [NUM_BKT];
  int          bkt_depth [NUM_BKT];
  int          glob_depth;
  int          free_bkt;
  logic signed [31:0] top_row;
  logic [3:0]  clear_depth_reg;

  function automatic void wipe_table(int depth);
    for (int i = 0; i < NUM_BKT; i++) begin
      tbl_dir[i] = '0;
      bkt_fill[i] = 0;
      bkt_depth[i] = 0;
    end
    glob_depth = depth;
    free_bkt = 1;
    top_row = -1;
  endfunction

  function automatic logic [31:0] key_mag(logic [31:0] k);
    return k[31] ? (~k + 32'd1) : k;
  endfunction

  // low glob_depth hash bits, reversed: hash bit 0 lands at the top of the index
  function automatic int slot_of(logic [31:0] h);
    int r;
    r = 0;
    for (int i = 0; i < glob_depth; i++)
      if (h[i]) r |= 1 << (glob_depth - 1 - i);
    return r & (NUM_BKT - 1);
  endfunction

  function automatic void split_at(int idx, logic [31:0] h);
    int b, nb, ld, nk, nm, span, half, base, first;
    logic side;
    logic [31:0] rh;
    logic [31:0] kk [BKT_CAP];
    logic [30:0] kr [BKT_CAP];
    b = tbl_dir[idx];
    nb = free_bkt;
    ld = bkt_depth[b];
    side = h[ld];
    nk = 0;
    nm = 0;
    free_bkt = nb + 1;
    for (int i = 0; i < bkt_fill[b] && i < BKT_CAP; i++) begin
      rh = key_mag(rec_key[b][i]);
      if (rh[ld] == side) begin
        kk[nk] = rec_key[b][i];
        kr[nk] = rec_row[b][i];
        nk++;
      end else begin
        rec_key[nb][nm] = rec_key[b][i];
        rec_row[nb][nm] = rec_row[b][i];
        nm++;
      end
    end
    for (int i = 0; i < nk; i++) begin
      rec_key[b][i] = kk[i];
      rec_row[b][i] = kr[i];
    end
    bkt_fill[b] = nk;
    bkt_fill[nb] = nm;
    bkt_depth[b] = ld + 1;
    bkt_depth[nb] = ld + 1;
    span = 1 << (glob_depth - ld);
    half = span >> 1;
    base = idx & ~(span - 1);
    first = side ? base : base + half;
    for (int i = first; i < first + half; i++)
      tbl_dir[i & (NUM_BKT - 1)] = nb[7:0];
  endfunction

  function automatic logic [1:0] insert_record(logic [31:0] k, logic [30:0] r);
    logic [31:0] h;
    int idx, b, n;
    h = key_mag(k);
    while (1'b1) begin
      idx = slot_of(h);
      b = tbl_dir[idx];
      if (bkt_fill[b] < BKT_CAP) begin
        rec_key[b][bkt_fill[b]] = k;
        rec_row[b][bkt_fill[b]] = r;
        bkt_fill[b]++;
        if ($signed({1'b0, r}) > top_row) top_row = {1'b0, r};
        return ST_OK;
      end
      if (bkt_depth[b] < glob_depth) begin
        if (free_bkt >= NUM_BKT) return ST_FULL;
        split_at(idx, h);
      end else if (glob_depth < DEPTH_MAX) begin
        n = 2 << glob_depth;
        for (int i = n - 1; i >= 0; i--)
          tbl_dir[i & (NUM_BKT - 1)] = tbl_dir[(i >> 1) & (NUM_BKT - 1)];
        glob_depth++;
      end else begin
        return ST_FULL;
      end
    end
    return ST_FULL;
  endfunction

  function automatic answer_t predict_answer(op_word_t w);
    answer_t a;
    int b;
    a.status = ST_OK;
    a.found_row = '0;
    if (w.opcode == OP_INSERT || w.opcode == OP_LOOKUP) begin
      if (w.key == BAD_KEY) begin
        a.status = ST_BAD_KEY;
      end else if (w.opcode == OP_INSERT) begin
        a.status = insert_record(w.key, w.row);
      end else begin
        a.status = ST_NOT_FOUND;
        b = tbl_dir[slot_of(key_mag(w.key))];
        for (int i = 0; i < bkt_fill[b] && i < BKT_CAP; i++) begin
          if (rec_key[b][i] == w.key && rec_row[b][i] >= w.row) begin
            a.status = ST_OK;
            a.found_row = rec_row[b][i];
            break;
          end
        end
      end
    end else if (w.opcode == OP_CLEAR) begin
      wipe_table(clear_depth_reg > DEPTH_MAX ? DEPTH_MAX : clear_depth_reg);
    end
    a.depth_now = glob_depth[3:0];
    a.largest_row = top_row;
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, receiver, monitor, watchdog
  // ---------------------------------------------------------------------------
  op_word_t stim_q[$];
  answer_t  answers_due[$];
  int send_idle_pct, recv_stall_pct;
  int hold_off;        // long receiver hold-off, counted down by the receiver
  int mismatches;
  int quiet_cycles;
  bit in_taken;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // sender: a new word only after the previous one was taken
  always @(negedge clk) begin
    op_word_t w;
    if (rst_n && (!in_valid || in_taken)) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = stim_q.pop_front();
        in_valid <= 1'b1;
        in_opcode <= w.opcode;
        in_key <= w.key;
        in_row <= w.row;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    op_word_t w;
    answer_t a;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        w.opcode = in_opcode;
        w.key = in_key;
        w.row = in_row;
        answers_due.push_back(predict_answer(w));
      end
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          report("unexpected word", {30'd0, out_status}, 32'd0);
        end else begin
          a = answers_due.pop_front();
          if (out_status !== a.status) report("status", out_status, a.status);
          if (out_found_row !== a.found_row) report("found_row", out_found_row, a.found_row);
          if (out_depth_now !== a.depth_now) report("depth_now", out_depth_now, a.depth_now);
          if (out_largest_row !== a.largest_row)
            report("largest_row", out_largest_row, a.largest_row);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_word(logic [1:0] op, logic [31:0] k, logic [30:0] r);
    op_word_t w;
    w.opcode = op;
    w.key = k;
    w.row = r;
    stim_q.push_back(w);
  endtask

  // small key magnitudes collide a lot, so buckets split and the directory grows
  function automatic logic [31:0] pick_key();
    int sel;
    logic [31:0] k;
    sel = $urandom_range(99);
    if (sel < 2) return BAD_KEY;
    if (sel < 15) return $urandom();
    k = $urandom_range(80);
    return $urandom_range(1) ? -k : k;
  endfunction

  task automatic add_random(int n);
    int sel;
    logic [30:0] r;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      r = $urandom_range(3) == 0 ? 31'($urandom_range(15)) : 31'($urandom());
      if (sel < 55) push_word(OP_INSERT, pick_key(), r);
      else if (sel < 93) push_word(OP_LOOKUP, pick_key(), $urandom_range(1) ? '0 : r);
      else if (sel < 97) push_word(OP_CLEAR, $urandom(), $urandom());
      else push_word(OP_UNUSED, $urandom(), $urandom());
    end
  endtask

  // waits until every queued word is sent and every answer is back
  task automatic drain();
    while (stim_q.size() != 0 || in_valid || answers_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_clear_depth(logic [3:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_start_depth <= v;
    do @(posedge clk); while (!cfg_ready);
    clear_depth_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_INSERT;
    in_key = '0;
    in_row = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_start_depth = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    mismatches = 0;
    quiet_cycles = 0;
    clear_depth_reg = '0;
    wipe_table(0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, every opcode, bad key, table full
    push_word(OP_LOOKUP, 32'd5, '0);                 // empty table
    push_word(OP_INSERT, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    push_word(OP_INSERT, 32'h8000_0001, '0);          // -INT_MAX, same hash
    push_word(OP_INSERT, 32'd0, 31'd3);
    push_word(OP_INSERT, 32'd0, 31'd3);               // duplicate record
    push_word(OP_LOOKUP, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    push_word(OP_LOOKUP, 32'h8000_0001, 31'd1);       // row below minimum
    push_word(OP_LOOKUP, 32'd0, 31'd2);
    push_word(OP_INSERT, BAD_KEY, 31'd9);
    push_word(OP_LOOKUP, BAD_KEY, '0);
    push_word(OP_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    // same low 8 hash bits: doubles to the top depth, then reports full
    for (int j = 0; j < 10; j++) push_word(OP_INSERT, 32'd5 + 32'd256 * j, 31'(j));
    push_word(OP_LOOKUP, 32'd5 + 32'd256 * 7, '0);
    push_word(OP_CLEAR, '0, '0);
    push_word(OP_LOOKUP, 32'd5, '0);
    drain();

    set_clear_depth(4'd8);
    push_word(OP_CLEAR, '0, '0);
    add_random(270);
    drain();

    set_clear_depth(4'd15);                           // saturates to the top depth
    push_word(OP_CLEAR, '0, '0);
    send_idle_pct = 69;
    add_random(270);
    drain();

    set_clear_depth(4'd3);
    push_word(OP_CLEAR, '0, '0);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    @(negedge clk);
    hold_off = 400;                                   // block backs up, input stalls
    add_random(270);
    drain();

    set_clear_depth(4'd0);
    push_word(OP_CLEAR, '0, '0);
    send_idle_pct = 22;
    recv_stall_pct = 22;
    add_random(270);
    drain();

    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ehash_pkg.sv
rtl/ehash_ram.sv
rtl/ehash_hash.sv
rtl/extendible_hash_table_unit.sv
rtl/ehash_chk.sv
bench/tb_top.sv
